// ===== hw/rtl/nlle_pkg.sv =====
package nlle_pkg;

  localparam int NODE_COUNT = 256;
  localparam int AGE_BITS   = 16;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(NODE_COUNT + 1);
  localparam int ID_W       = 8;
  localparam int TMO_W      = 16;
  localparam int CHG_W      = 9;
  localparam int CMP_W      = (AGE_BITS > TMO_W) ? AGE_BITS : TMO_W;

  localparam logic [TMO_W-1:0]    TMO_RESET = TMO_W'(40);
  localparam logic [AGE_BITS-1:0] AGE_MAX   = {AGE_BITS{1'b1}};
  localparam logic                KIND_PKT  = 1'b0;
  localparam logic                KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } scan_state_e;

  typedef struct packed {
    logic [AGE_BITS-1:0] age;
    logic                online;
  } entry_t;

  typedef struct packed {
    logic             set_seen;
    logic [IDX_W-1:0] set_idx;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_data;
  } tbl_req_t;

  typedef struct packed {
    entry_t rd_data;
    logic   rd_seen;
  } tbl_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]  leader_id;
    logic             leader_valid;
    logic             leader_announce;
    logic [CHG_W-1:0] online_changes;
  } result_t;

endpackage

// ===== hw/rtl/nlle_if.sv =====
interface nlle_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [nlle_pkg::ID_W-1:0] node_id;

  modport source (output valid, output kind, output node_id, input ready);
  modport sink (input valid, input kind, input node_id, output ready);
endinterface

interface nlle_out_if;
  logic                       valid;
  logic                       ready;
  logic [nlle_pkg::ID_W-1:0]  leader_id;
  logic                       leader_valid;
  logic                       leader_announce;
  logic [nlle_pkg::CHG_W-1:0] online_changes;

  modport source (output valid, output leader_id, output leader_valid,
                  output leader_announce, output online_changes, input ready);
  modport sink (input valid, input leader_id, input leader_valid,
                input leader_announce, input online_changes, output ready);
endinterface

// ===== hw/rtl/nlle_table.sv =====
module nlle_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nlle_pkg::tbl_req_t req_i,
  output nlle_pkg::tbl_rsp_t rsp_o
);

  nlle_pkg::entry_t                  mem_q [nlle_pkg::NODE_COUNT];
  logic [nlle_pkg::NODE_COUNT-1:0]   seen_q;
  nlle_pkg::entry_t                  rd_data_q;
  logic                              rd_seen_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_idx] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_idx];
      rd_seen_q <= seen_q[req_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (req_i.set_seen) begin
      seen_q[req_i.set_idx] <= 1'b1;
    end
  end

  assign rsp_o.rd_data = rd_data_q;
  assign rsp_o.rd_seen = rd_seen_q;

endmodule

// ===== hw/rtl/nlle_scan.sv =====
module nlle_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_kind_i,
  input  logic [nlle_pkg::ID_W-1:0]   in_id_i,
  output logic                        in_ready_o,
  input  logic [nlle_pkg::TMO_W-1:0]  timeout_i,
  output nlle_pkg::tbl_req_t          tbl_req_o,
  input  nlle_pkg::tbl_rsp_t          tbl_rsp_i,
  input  logic                        res_free_i,
  output logic                        res_load_o,
  output nlle_pkg::result_t           res_o
);

  nlle_pkg::scan_state_e state_q, state_d;

  logic [nlle_pkg::CNT_W-1:0]    cnt_q;
  logic                          vld_q;
  logic [nlle_pkg::IDX_W-1:0]    idx_q;
  logic                          tick_q;
  logic                          hit_q;
  logic [nlle_pkg::IDX_W-1:0]    pid_q;
  logic [nlle_pkg::CNT_W-1:0]    chg_q;
  logic                          found_q;
  logic [nlle_pkg::IDX_W-1:0]    best_q;
  logic [nlle_pkg::AGE_BITS-1:0] best_age_q;
  logic                          lead_ok_q;
  logic [nlle_pkg::IDX_W-1:0]    leader_q;
  logic                          held_q;

  logic                          accept;
  logic                          in_hit;
  nlle_pkg::entry_t              old_ent;
  logic [nlle_pkg::AGE_BITS-1:0] age_new;
  logic                          on_new;
  logic                          flip;
  logic                          better;
  logic                          held_ok;

  assign accept = in_valid_i && in_ready_o;
  assign in_hit = (in_kind_i == nlle_pkg::KIND_PKT) &&
                  ({1'b0, in_id_i} < (nlle_pkg::ID_W + 1)'(nlle_pkg::NODE_COUNT));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nlle_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = nlle_pkg::ST_SCAN;
      end
      nlle_pkg::ST_SCAN: begin
        if (cnt_q == nlle_pkg::CNT_W'(nlle_pkg::NODE_COUNT - 1)) state_d = nlle_pkg::ST_DRAIN;
      end
      nlle_pkg::ST_DRAIN: begin
        state_d = nlle_pkg::ST_DONE;
      end
      nlle_pkg::ST_DONE: begin
        if (res_free_i) state_d = nlle_pkg::ST_IDLE;
      end
      default: state_d = nlle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    old_ent = tbl_rsp_i.rd_data;
    if (hit_q && (idx_q == pid_q)) begin
      old_ent.age    = '0;
      old_ent.online = 1'b1;
    end
    if (tick_q && (old_ent.age != nlle_pkg::AGE_MAX)) begin
      age_new = old_ent.age + 1'b1;
    end else begin
      age_new = old_ent.age;
    end
    on_new = nlle_pkg::CMP_W'(age_new) <= nlle_pkg::CMP_W'(timeout_i);
    flip   = tbl_rsp_i.rd_seen && (on_new != old_ent.online);
    better = tbl_rsp_i.rd_seen && on_new && (!found_q || (age_new < best_age_q));
  end

  assign held_ok = held_q && lead_ok_q;

  always_comb begin
    in_ready_o = (state_q == nlle_pkg::ST_IDLE);
    res_load_o = (state_q == nlle_pkg::ST_DONE) && res_free_i;

    tbl_req_o.set_seen     = accept && in_hit;
    tbl_req_o.set_idx      = in_id_i[nlle_pkg::IDX_W-1:0];
    tbl_req_o.rd_en        = (state_q == nlle_pkg::ST_SCAN);
    tbl_req_o.rd_idx       = cnt_q[nlle_pkg::IDX_W-1:0];
    tbl_req_o.wr_en        = vld_q && tbl_rsp_i.rd_seen;
    tbl_req_o.wr_idx       = idx_q;
    tbl_req_o.wr_data.age    = age_new;
    tbl_req_o.wr_data.online = on_new;

    res_o.online_changes = nlle_pkg::CHG_W'(chg_q);
    if (held_ok) begin
      res_o.leader_id       = nlle_pkg::ID_W'(leader_q);
      res_o.leader_valid    = 1'b1;
      res_o.leader_announce = 1'b0;
    end else if (found_q) begin
      res_o.leader_id       = nlle_pkg::ID_W'(best_q);
      res_o.leader_valid    = 1'b1;
      res_o.leader_announce = 1'b1;
    end else begin
      res_o.leader_id       = '0;
      res_o.leader_valid    = 1'b0;
      res_o.leader_announce = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= nlle_pkg::ST_IDLE;
      cnt_q    <= '0;
      vld_q    <= 1'b0;
      leader_q <= '0;
      held_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= tbl_req_o.rd_en;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == nlle_pkg::ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (res_load_o) begin
        held_q <= held_ok || found_q;
        if (!held_ok && found_q) leader_q <= best_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= tbl_req_o.rd_idx;
    if (accept) begin
      tick_q    <= (in_kind_i != nlle_pkg::KIND_PKT);
      hit_q     <= in_hit;
      pid_q     <= in_id_i[nlle_pkg::IDX_W-1:0];
      chg_q     <= '0;
      found_q   <= 1'b0;
      lead_ok_q <= 1'b0;
    end else if (vld_q) begin
      if (flip) chg_q <= chg_q + 1'b1;
      if (better) begin
        found_q    <= 1'b1;
        best_q     <= idx_q;
        best_age_q <= age_new;
      end
      if (idx_q == leader_q) lead_ok_q <= tbl_rsp_i.rd_seen && on_new;
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nlle_pkg::ST_IDLE |-> !vld_q)
    else $error("read data pending while idle");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> $past(state_q) == nlle_pkg::ST_SCAN)
    else $error("read data without a scan read");

  a_chg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == nlle_pkg::ST_DONE |-> chg_q <= cnt_q)
    else $error("more flips counted than entries scanned");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load_o |=> state_q == nlle_pkg::ST_IDLE && !vld_q)
    else $error("scan did not return to idle after result");
`endif

endmodule

// ===== hw/rtl/node_liveness_leader_elect_unit.sv =====
// Node liveness table with leader election.
// pkt_i carries one transaction per event: kind 0 is a packet from node_id,
// kind 1 is a time tick. res_o returns one transaction per accepted event with
// the current leader, whether it is held, whether it was just elected, and
// how many nodes flipped their online flag.
// cfg_we_i/cfg_wdata_i write the timeout in ticks; write only while idle.
// Each event sweeps the node table held in one synchronous RAM, one entry per
// cycle through a read, update and write-back pipeline. The result is loaded
// into the output register after the sweep and a drain step, and the next
// event is taken only once that load is done, so events do not overlap; the
// single RAM port pair walking every entry sets the pace.
// Reset clears the seen flags, the leader and the timeout (to 40) at once;
// no clearing pass is needed. If res_o is stalled, the finished result waits
// in the output register and the next event is still swept; its result is
// held until the output register frees up.
module node_liveness_leader_elect_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  nlle_in_if.sink                    pkt_i,
  nlle_out_if.source                 res_o,
  input  logic                       cfg_we_i,
  input  logic [nlle_pkg::TMO_W-1:0] cfg_wdata_i
);

  logic [nlle_pkg::TMO_W-1:0] tmo_q;
  nlle_pkg::tbl_req_t         tbl_req;
  nlle_pkg::tbl_rsp_t         tbl_rsp;
  nlle_pkg::result_t          res;
  nlle_pkg::result_t          res_q;
  logic                       res_load;
  logic                       res_free;
  logic                       out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q <= nlle_pkg::TMO_RESET;
    end else if (cfg_we_i) begin
      tmo_q <= cfg_wdata_i;
    end
  end

  nlle_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  nlle_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pkt_i.valid),
    .in_kind_i  (pkt_i.kind),
    .in_id_i    (pkt_i.node_id),
    .in_ready_o (pkt_i.ready),
    .timeout_i  (tmo_q),
    .tbl_req_o  (tbl_req),
    .tbl_rsp_i  (tbl_rsp),
    .res_free_i (res_free),
    .res_load_o (res_load),
    .res_o      (res)
  );

  assign res_free = !out_vld_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res;
  end

  assign res_o.valid           = out_vld_q;
  assign res_o.leader_id       = res_q.leader_id;
  assign res_o.leader_valid    = res_q.leader_valid;
  assign res_o.leader_announce = res_q.leader_announce;
  assign res_o.online_changes  = res_q.online_changes;

endmodule
